[rtl/bpm_pkg.sv]
// Package for the bracket pair matcher: beat types, status codes, stack sizes.
// Used by bpm_stack, bracket_pair_matcher, bpm_checker and the testbench; depends on nothing.
`default_nettype none

package bpm_pkg;

    // Stack sizing and reported position width
    localparam int unsigned STACK_ENTRIES = 1024;
    localparam int unsigned ADDR_W        = 10;
    localparam int unsigned DEPTH_W       = 11;
    localparam int unsigned POS_W         = 10;
    localparam int unsigned MAX_LEN_DEF   = 1024;

    // Character codes
    localparam logic [7:0] SYM_OPEN   = 8'h3E;
    localparam logic [7:0] SYM_CLOSE  = 8'h3C;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NONPRINT  = 3'd1,
        ST_UNMATCHED = 3'd2,
        ST_UNCLOSED  = 3'd3,
        ST_TOOLONG   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_last;
    } sym_beat_t;

    typedef struct packed {
        logic              pair_valid;
        logic [POS_W-1:0]  open_pos;
        logic [POS_W-1:0]  close_pos;
        logic              string_done;
        status_t           status;
    } pair_beat_t;

    // Stack commands from the matcher control
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_cmd_t;

endpackage

`default_nettype wire

[rtl/bpm_stack.sv]
// Open-position stack: top entry in a register, the rest in a memory whose
// registered read always prefetches the entry below the top. Uses bpm_pkg.
`default_nettype none

module bpm_stack (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bpm_pkg::stk_cmd_t             cmd,
    input  wire logic [bpm_pkg::POS_W-1:0]     push_data,
    output logic [bpm_pkg::POS_W-1:0]          top,
    output logic [bpm_pkg::DEPTH_W-1:0]        depth
);
    import bpm_pkg::*;

    logic [POS_W-1:0]   mem [STACK_ENTRIES];
    logic [POS_W-1:0]   tos_reg;
    logic [POS_W-1:0]   tos_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [POS_W-1:0]   rd_data_reg;
    logic [POS_W-1:0]   byp_data_reg;
    logic               byp_hit_reg;
    logic               byp_hit_next;
    logic [POS_W-1:0]   below;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_next_m2;

    // Entry just below the top; a write to the prefetched slot is forwarded
    assign below = byp_hit_reg ? byp_data_reg : rd_data_reg;

    // On a push the old top spills into the memory
    assign depth_m1      = depth_reg - DEPTH_W'(1);
    assign wr_en         = cmd.push && (depth_reg != '0);
    assign wr_addr       = depth_m1[ADDR_W-1:0];
    assign depth_next_m2 = depth_next - DEPTH_W'(2);
    assign rd_addr       = depth_next_m2[ADDR_W-1:0];
    assign byp_hit_next  = wr_en && (wr_addr == rd_addr);

    // Depth and top-of-stack update
    always_comb
    begin
        depth_next = depth_reg;
        tos_next   = tos_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
            tos_next   = push_data;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_m1;
            tos_next   = below;
        end
        if (cmd.clear)
            depth_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    // Payload registers and memory
    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        byp_data_reg <= tos_reg;
        if (wr_en)
            mem[wr_addr] <= tos_reg;
        rd_data_reg  <= mem[rd_addr];
    end

    assign top   = tos_reg;
    assign depth = depth_reg;

endmodule

`default_nettype wire

[rtl/bracket_pair_matcher.sv]
// Bracket pair matcher: takes a structure string one character per beat and
// returns one result beat per character. A '>' pushes its position, a '<' pops
// the latest open position and reports the pair; any other printable character
// is unpaired. The first error of a string sticks and stops further pairs; the
// beat marked last carries the final status and clears the block for the next
// string. One character is accepted every clock cycle unless the result side
// stalls; a character is captured in the input register, then decoded into
// the result register as both stages advance. The rate is set by the push/pop
// on the top-of-stack register, with the stack memory's registered read port
// prefetching the entry below the top. The stack memory needs no clearing
// pass after reset.
// Depends on bpm_pkg and bpm_stack.
`default_nettype none

module bracket_pair_matcher #(
    parameter int unsigned MAX_LEN = bpm_pkg::MAX_LEN_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bpm_pkg::sym_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bpm_pkg::pair_beat_t      out_data
);
    import bpm_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LEN + 1);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    sym_beat_t  in_data_reg;
    logic       in_fire;
    logic       advance;

    // String state
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    status_t            err_reg;
    status_t            err_next;
    stk_cmd_t           stk_cmd;
    logic [POS_W-1:0]   stk_top;
    logic [DEPTH_W-1:0] stk_depth;
    logic               depth_after_nz;

    // Result register
    logic       out_valid_reg;
    logic       out_valid_next;
    pair_beat_t out_data_reg;
    pair_beat_t res;

    // Handshake: both stages move together
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Character decode and stack control
    always_comb
    begin
        err_next       = err_reg;
        pos_next       = pos_reg;
        stk_cmd        = '0;
        res            = '0;
        res.status     = ST_OK;
        depth_after_nz = (stk_depth != '0);

        if (err_reg == ST_OK)
        begin
            if (pos_reg >= PW'(MAX_LEN))
                err_next = ST_TOOLONG;
            else if ((in_data_reg.symbol < PRINT_LO) || (in_data_reg.symbol > PRINT_HI))
                err_next = ST_NONPRINT;
            else if (in_data_reg.symbol == SYM_OPEN)
            begin
                if (stk_depth >= DEPTH_W'(STACK_ENTRIES))
                    err_next = ST_TOOLONG;
                else
                begin
                    stk_cmd.push   = advance;
                    depth_after_nz = 1'b1;
                end
            end
            else if (in_data_reg.symbol == SYM_CLOSE)
            begin
                if (stk_depth == '0)
                    err_next = ST_UNMATCHED;
                else
                begin
                    stk_cmd.pop    = advance;
                    depth_after_nz = (stk_depth != DEPTH_W'(1));
                    res.pair_valid = 1'b1;
                    res.open_pos   = stk_top;
                    res.close_pos  = POS_W'(pos_reg);
                end
            end
            if (err_next == ST_OK)
                pos_next = pos_reg + PW'(1);
        end

        // Last character: report and clear for the next string
        if (in_data_reg.is_last)
        begin
            if ((err_next == ST_OK) && depth_after_nz)
                err_next = ST_UNCLOSED;
            res.string_done = 1'b1;
            res.status      = err_next;
            err_next        = ST_OK;
            pos_next        = '0;
            stk_cmd.clear   = advance;
        end
    end

    bpm_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .push_data (POS_W'(pos_reg)),
        .top       (stk_top),
        .depth     (stk_depth)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg <= pos_next;
                err_reg <= err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_depth <= DEPTH_W'(STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.string_done) |-> (out_data.status == ST_OK))
        else $error("status on a result that is not the last");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.is_last) |=> ((pos_reg == '0) && (stk_depth == '0)
                                              && (err_reg == ST_OK)))
        else $error("string state not cleared after last character");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != ST_OK) && !(advance && in_data_reg.is_last))
            |=> (err_reg == $past(err_reg)))
        else $error("error code changed before end of string");

    a_no_pair_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (err_reg != ST_OK)) |=> !out_data.pair_valid)
        else $error("pair reported after an error");

endmodule

`default_nettype wire

[verif/bpm_checker.sv]
// Scoreboard for the bracket pair matcher: watches both channels, predicts each
// result beat from the accepted character beats and compares field by field.
// Depends on bpm_pkg for the beat types, status codes and stack sizes.
module bpm_checker #(
    parameter int unsigned MAX_LEN = bpm_pkg::MAX_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  bpm_pkg::sym_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bpm_pkg::pair_beat_t out_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bpm_pkg::*;

    // Shadow copy of the matcher state
    int unsigned     cur_pos    = 0;
    int unsigned     open_count = 0;
    status_t         first_err  = ST_OK;
    logic [POS_W-1:0] open_marks [STACK_ENTRIES];

    pair_beat_t pair_q[$];
    int mismatches   = 0;
    int queued       = 0;
    int results_seen = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Advance the shadow state by one character and build its result beat
    task automatic predict_pair(input sym_beat_t beat, output pair_beat_t res);
        res        = '0;
        res.status = ST_OK;
        if (first_err == ST_OK) begin
            if (cur_pos >= MAX_LEN)
                first_err = ST_TOOLONG;
            else if (beat.symbol < PRINT_LO || beat.symbol > PRINT_HI)
                first_err = ST_NONPRINT;
            else if (beat.symbol == SYM_OPEN) begin
                if (open_count >= STACK_ENTRIES)
                    first_err = ST_TOOLONG;
                else
                begin
                    open_marks[open_count % STACK_ENTRIES] = cur_pos[POS_W-1:0];
                    open_count++;
                end
            end
            else if (beat.symbol == SYM_CLOSE) begin
                if (open_count == 0)
                    first_err = ST_UNMATCHED;
                else
                begin
                    open_count--;
                    res.pair_valid = 1'b1;
                    res.open_pos   = open_marks[open_count % STACK_ENTRIES];
                    res.close_pos  = cur_pos[POS_W-1:0];
                end
            end
            if (first_err == ST_OK && cur_pos < MAX_LEN)
                cur_pos++;
        end
        // Last mark ends the string whatever happened before
        if (beat.is_last) begin
            if (first_err == ST_OK && open_count != 0)
                first_err = ST_UNCLOSED;
            res.string_done = 1'b1;
            res.status      = first_err;
            cur_pos    = 0;
            open_count = 0;
            first_err  = ST_OK;
        end
    endtask

    // Compare result beats against the oldest prediction, then predict new ones
    always @(posedge clk or negedge rst_n)
    begin
        pair_beat_t want;
        pair_beat_t fresh;
        if (!rst_n) begin
            cur_pos    = 0;
            open_count = 0;
            first_err  = ST_OK;
            pair_q.delete();
            queued <= 0;
        end
        else
        begin
            if (out_valid && out_ready) begin
                if (pair_q.size() == 0)
                    report_mismatch("unexpected beat, pair_valid", out_data.pair_valid, 0);
                else
                begin
                    want = pair_q.pop_front();
                    if (out_data.pair_valid !== want.pair_valid)
                        report_mismatch("pair_valid", out_data.pair_valid, want.pair_valid);
                    if (out_data.open_pos !== want.open_pos)
                        report_mismatch("open_pos", out_data.open_pos, want.open_pos);
                    if (out_data.close_pos !== want.close_pos)
                        report_mismatch("close_pos", out_data.close_pos, want.close_pos);
                    if (out_data.string_done !== want.string_done)
                        report_mismatch("string_done", out_data.string_done,
                                        want.string_done);
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                end
                results_seen++;
            end
            if (in_valid && in_ready) begin
                predict_pair(in_data, fresh);
                pair_q.push_back(fresh);
            end
            queued <= pair_q.size();
        end
    end

endmodule

[verif/tb_bracket_pair_matcher.sv]
// Testbench top for the bracket pair matcher: clock, reset, character stimulus
// and result back-pressure; checking is done by bpm_checker.
// Depends on bpm_pkg, bracket_pair_matcher and bpm_checker.
module tb_bracket_pair_matcher;
    timeunit 1ns;
    timeprecision 1ps;
    import bpm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int unsigned MATCH_LEN = MAX_LEN_DEF;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    sym_beat_t  in_data;
    logic       out_valid;
    logic       out_ready;
    pair_beat_t out_data;
    int         fail_count;
    int         pending;

    bit         calm = 1'b0;     // no idling on either side while set
    logic [7:0] chars[$];        // string being built for the next send
    int         sent_items = 0;

    bracket_pair_matcher #(
        .MAX_LEN (MATCH_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    bpm_checker #(
        .MAX_LEN (MATCH_LEN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int idle_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Printable character that is neither bracket mark
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(PRINT_LO, PRINT_HI));
        while (c == SYM_OPEN || c == SYM_CLOSE);
        return c;
    endfunction

    task automatic send_beat(input logic [7:0] sym, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= '{symbol: sym, is_last: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        sent_items++;
    endtask

    task automatic send_string();
        foreach (chars[i])
            send_beat(chars[i], i == chars.size() - 1);
        chars.delete();
    endtask

    // Append len characters; balanced strings close every open they make
    task automatic add_structure(input int len, input bit balanced);
        int depth;
        int rem;
        int pick;
        depth = 0;
        for (int i = 0; i < len; i++) begin
            rem  = len - i;
            pick = $urandom_range(0, 2);
            if (balanced && depth >= rem)
                pick = 1;
            if (pick == 0 && (!balanced || depth + 1 < rem)) begin
                chars.push_back(SYM_OPEN);
                depth++;
            end
            else if (pick == 1 && (!balanced || depth > 0)) begin
                chars.push_back(SYM_CLOSE);
                if (depth > 0)
                    depth--;
            end
            else
                chars.push_back(plain_char());
        end
    endtask

    // Result side: random stall before each beat, stretches without stalls
    initial
    begin
        out_ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            int gap;
            gap = idle_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Character side and verdict
    initial
    begin
        int len;
        int kind;
        int code;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: single pair, unmatched, unclosed and nonprintable errors, printable bounds
        chars = '{SYM_OPEN, SYM_CLOSE};                    send_string();
        chars = '{SYM_CLOSE};                              send_string();
        chars = '{SYM_OPEN};                               send_string();
        chars = '{8'h1F};                                  send_string();
        chars = '{PRINT_LO, PRINT_HI, SYM_OPEN, SYM_CLOSE}; send_string();
        chars = '{8'h00};                                  send_string();
        // error sticks: nothing after a nonprintable pairs up
        chars = '{8'h7F, SYM_OPEN, SYM_CLOSE};             send_string();
        chars = '{8'hFF};                                  send_string();
        // last beat closes a pair and still leaves an open behind
        chars = '{SYM_OPEN, SYM_OPEN, SYM_CLOSE};          send_string();
        chars = '{SYM_CLOSE, SYM_OPEN, SYM_CLOSE};         send_string();
        chars = '{SYM_OPEN, SYM_OPEN, SYM_OPEN, SYM_CLOSE, SYM_CLOSE, SYM_CLOSE};
        send_string();
        sent_items = 0;

        // Full-length string: pairs out to the last position, then too long
        repeat (MATCH_LEN / 2) chars.push_back(SYM_OPEN);
        repeat (MATCH_LEN / 2) chars.push_back(SYM_CLOSE);
        chars.push_back(SYM_OPEN);
        chars.push_back(SYM_CLOSE);
        send_string();

        // Random strings, mostly well formed
        while (sent_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120)
                                               : $urandom_range(1, 24);
            kind = $urandom_range(0, 99);
            if (kind < 60)
                add_structure(len, 1'b1);
            else if (kind < 72) begin
                add_structure(len, 1'b1);
                repeat ($urandom_range(1, 3)) chars.push_front(SYM_OPEN);
            end
            else if (kind < 84)
                add_structure(len, 1'b0);
            else if (kind < 94) begin
                add_structure(len, 1'b1);
                code = $urandom_range(0, 160);
                chars[$urandom_range(0, chars.size() - 1)] = 8'(code < 32 ? code : code + 95);
            end
            else
                repeat (len) chars.push_back(8'($urandom_range(0, 255)));
            send_string();
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
